/* design/rlfm_pkg.sv */
`default_nettype none
package rlfm_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int QUEUE_DEPTH = 16;

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int WADDR_W = $clog2(NUM_SLOTS * QUEUE_DEPTH);
    localparam int WAITER_W = 48;

    localparam logic OP_ENTER = 1'b0;
    localparam logic OP_LEAVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_TABLE_FULL  = 2'd1,
        ST_QUEUE_FULL  = 2'd2,
        ST_EMPTY_LEAVE = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic match;
        logic lookup;
        logic exec;
        logic load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_stat;

    // ring pointer advance, b can reach the depth; one subtraction wraps the sum
    function automatic logic [QPTR_W-1:0] wrap_ptr(input logic [QPTR_W-1:0] a,
                                                   input logic [QCNT_W-1:0] b);
        logic [QCNT_W:0] sum;
        sum = (QCNT_W+1)'(a) + (QCNT_W+1)'(b);
        if (sum >= (QCNT_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (QCNT_W+1)'(QUEUE_DEPTH);
        end
        return sum[QPTR_W-1:0];
    endfunction

    function automatic logic [3:0] slot_out(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+3:0] w;
        w = {4'b0000, s};
        return w[3:0];
    endfunction

    function automatic logic [WADDR_W-1:0] waiter_addr(input logic [SLOT_W-1:0] s,
                                                       input logic [QPTR_W-1:0] p);
        return WADDR_W'(s) * WADDR_W'(QUEUE_DEPTH) + WADDR_W'(p);
    endfunction

endpackage
`default_nettype wire

/* design/resource_lock_fifo_manager_unit.sv */
// channel   handshake                  payload
// request   i_in_valid / o_in_ready    i_operation i_resource_key i_requester_addr
//                                      i_requester_port
// result    o_out_valid / i_out_ready  o_grant o_granted_addr o_granted_port
//                                      o_slot_index o_status
//
// one request at a time: accept, key compare, slot select, queue update, then
// the result enters the output register when that register is free
// a new request is taken in the cycle after the result is loaded, and none
// before it, so each request runs through all sequencer steps on its own
// a stalled result holds in the output register while the next request runs
// synchronous active-low reset clears slot table valid bits and queue counters
`default_nettype none
module resource_lock_fifo_manager_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_operation,
    input  wire logic [31:0] i_resource_key,
    input  wire logic [31:0] i_requester_addr,
    input  wire logic [15:0] i_requester_port,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_grant,
    output logic [31:0]      o_granted_addr,
    output logic [15:0]      o_granted_port,
    output logic [3:0]       o_slot_index,
    output logic [1:0]       o_status
);
    import rlfm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rlfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rlfm_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_operation      (i_operation),
        .i_resource_key   (i_resource_key),
        .i_requester_addr (i_requester_addr),
        .i_requester_port (i_requester_port),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_grant          (o_grant),
        .o_granted_addr   (o_granted_addr),
        .o_granted_port   (o_granted_port),
        .o_slot_index     (o_slot_index),
        .o_status         (o_status)
    );
endmodule
`default_nettype wire

/* design/rlfm_ram.sv */
`default_nettype none
module rlfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* design/rlfm_ctrl.sv */
`default_nettype none
module rlfm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire rlfm_pkg::t_stat i_stat,
    output rlfm_pkg::t_cmd      o_cmd
);
    import rlfm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MATCH  = 5'b00010,
        S_LOOKUP = 5'b00100,
        S_EXEC   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_MATCH;
            S_MATCH:  n_state = S_LOOKUP;
            S_LOOKUP: n_state = S_EXEC;
            S_EXEC:   n_state = S_DONE;
            S_DONE:   if (i_stat.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.match    = (r_state == S_MATCH);
    assign o_cmd.lookup   = (r_state == S_LOOKUP);
    assign o_cmd.exec     = (r_state == S_EXEC);
    assign o_cmd.load     = (r_state == S_DONE) && i_stat.out_free;
endmodule
`default_nettype wire

/* design/rlfm_dpath.sv */
`default_nettype none
module rlfm_dpath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rlfm_pkg::t_cmd i_cmd,
    output rlfm_pkg::t_stat     o_stat,
    input  wire logic           i_operation,
    input  wire logic [31:0]    i_resource_key,
    input  wire logic [31:0]    i_requester_addr,
    input  wire logic [15:0]    i_requester_port,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic                o_grant,
    output logic [31:0]         o_granted_addr,
    output logic [15:0]         o_granted_port,
    output logic [3:0]          o_slot_index,
    output logic [1:0]          o_status
);
    import rlfm_pkg::*;

    // captured transaction
    logic                r_op;
    logic [31:0]         r_key;
    logic [WAITER_W-1:0] r_waiter;

    // slot table
    logic                r_slot_used [NUM_SLOTS];
    logic [31:0]         r_slot_key  [NUM_SLOTS];
    logic [QPTR_W-1:0]   r_queue_head  [NUM_SLOTS];
    logic [QCNT_W-1:0]   r_queue_count [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] r_hit_vec, r_free_vec;

    logic [SLOT_W-1:0]   r_slot;
    logic [QPTR_W-1:0]   r_head;
    logic [QCNT_W-1:0]   r_cnt;
    logic                r_tfull;

    // pending result
    logic                r_res_grant;
    t_status             r_res_status;
    logic [3:0]          r_res_slot;
    logic                r_res_use_ram;

    // output register
    logic                r_out_valid;
    logic                r_out_grant;
    logic [WAITER_W-1:0] r_out_waiter;
    logic [3:0]          r_out_slot;
    t_status             r_out_status;

    // lookup
    logic                hit, any_free, alloc;
    logic [SLOT_W-1:0]   hit_idx, free_idx, sel_slot;

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (r_hit_vec[s])  hit_idx  = SLOT_W'(s);
            if (r_free_vec[s]) free_idx = SLOT_W'(s);
        end
        hit      = |r_hit_vec;
        any_free = |r_free_vec;
        alloc    = i_cmd.lookup && !hit && any_free;
        sel_slot = hit ? hit_idx : free_idx;
    end

    // queue operation
    logic                ram_we, ram_re, q_wr;
    logic [WADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [QPTR_W-1:0]   wr_ptr, nxt_head, q_head;
    logic [QCNT_W-1:0]   q_cnt;
    logic                e_grant, e_use_ram;
    t_status             e_status;
    logic [WAITER_W-1:0] ram_rdata;

    always_comb begin
        wr_ptr    = wrap_ptr(r_head, r_cnt);
        nxt_head  = wrap_ptr(r_head, QCNT_W'(1));
        ram_waddr = waiter_addr(r_slot, wr_ptr);
        ram_raddr = waiter_addr(r_slot, nxt_head);
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        q_wr      = 1'b0;
        q_head    = r_head;
        q_cnt     = r_cnt;
        e_grant   = 1'b0;
        e_use_ram = 1'b0;
        e_status  = ST_OK;
        if (r_tfull) begin
            e_status = ST_TABLE_FULL;
        end else if (r_op == OP_ENTER) begin
            if (r_cnt == QCNT_W'(QUEUE_DEPTH)) begin
                e_status = ST_QUEUE_FULL;
            end else begin
                ram_we  = i_cmd.exec;
                q_wr    = i_cmd.exec;
                q_cnt   = r_cnt + QCNT_W'(1);
                e_grant = (r_cnt == '0);
            end
        end else begin
            if (r_cnt == '0) begin
                e_status = ST_EMPTY_LEAVE;
            end else begin
                q_wr   = i_cmd.exec;
                q_head = nxt_head;
                q_cnt  = r_cnt - QCNT_W'(1);
                // new head exists only if more than one waiter was queued
                if (r_cnt != QCNT_W'(1)) begin
                    ram_re    = i_cmd.exec;
                    e_grant   = 1'b1;
                    e_use_ram = 1'b1;
                end
            end
        end
    end

    rlfm_ram #(
        .WIDTH (WAITER_W),
        .DEPTH (NUM_SLOTS * QUEUE_DEPTH)
    ) u_waiters (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_waiter),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_operation;
            r_key    <= i_resource_key;
            r_waiter <= {i_requester_addr, i_requester_port};
        end
        if (i_cmd.match) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_hit_vec[s]  <= r_slot_used[s] && (r_slot_key[s] == r_key);
                r_free_vec[s] <= !r_slot_used[s];
            end
        end
        if (i_cmd.lookup) begin
            r_slot  <= sel_slot;
            r_tfull <= !hit && !any_free;
            r_head  <= alloc ? '0 : r_queue_head[sel_slot];
            r_cnt   <= alloc ? '0 : r_queue_count[sel_slot];
        end
        if (alloc) begin
            r_slot_key[sel_slot] <= r_key;
        end
        if (i_cmd.exec) begin
            r_res_grant   <= e_grant;
            r_res_status  <= e_status;
            r_res_slot    <= r_tfull ? 4'd0 : slot_out(r_slot);
            r_res_use_ram <= e_use_ram;
        end
        if (i_cmd.load) begin
            r_out_grant  <= r_res_grant;
            r_out_slot   <= r_res_slot;
            r_out_status <= r_res_status;
            if (r_res_use_ram) begin
                r_out_waiter <= ram_rdata;
            end else if (r_res_grant) begin
                r_out_waiter <= r_waiter;
            end else begin
                r_out_waiter <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_slot_used[s]   <= 1'b0;
                r_queue_head[s]  <= '0;
                r_queue_count[s] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (alloc) begin
                r_slot_used[sel_slot]   <= 1'b1;
                r_queue_head[sel_slot]  <= '0;
                r_queue_count[sel_slot] <= '0;
            end
            if (q_wr) begin
                r_queue_head[r_slot]  <= q_head;
                r_queue_count[r_slot] <= q_cnt;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_grant        = r_out_grant;
    assign o_granted_addr = r_out_waiter[47:16];
    assign o_granted_port = r_out_waiter[15:0];
    assign o_slot_index   = r_out_slot;
    assign o_status       = r_out_status;
endmodule
`default_nettype wire

/* design/rlfm_checker.sv */
`default_nettype none
module rlfm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_grant,
    input wire logic [31:0] o_granted_addr,
    input wire logic [15:0] o_granted_port,
    input wire logic [3:0]  o_slot_index,
    input wire logic [1:0]  o_status
);
    import rlfm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_grant |-> o_granted_addr == 32'd0 && o_granted_port == 16'd0)
        else $error("requester fields set without grant");

    a_err_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> !o_grant)
        else $error("grant with error status");

    a_tfull_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_TABLE_FULL |-> o_slot_index == 4'd0)
        else $error("table full with nonzero slot");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind resource_lock_fifo_manager_unit rlfm_checker u_rlfm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_grant        (o_grant),
    .o_granted_addr (o_granted_addr),
    .o_granted_port (o_granted_port),
    .o_slot_index   (o_slot_index),
    .o_status       (o_status)
);
`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none
module tb_top;
    import rlfm_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 20;
    localparam int N_DIR        = 15;

    typedef struct packed {
        logic        grant;
        logic [31:0] addr;
        logic [15:0] port;
        logic [3:0]  slot;
        t_status     status;
    } t_lock_result;

    typedef struct packed {
        logic        op;
        logic [31:0] key;
        logic [31:0] addr;
        logic [15:0] port;
        logic [4:0]  reps;     // copies with addr stepped by one each
        logic        kstep;    // key stepped along with addr
        logic        typed;
        logic        w_grant;
        logic [31:0] w_addr;
        logic [15:0] w_port;
        logic [3:0]  w_slot;
        t_status     w_status;
    } t_lock_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_operation;
    logic [31:0] i_resource_key;
    logic [31:0] i_requester_addr;
    logic [15:0] i_requester_port;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_grant;
    logic [31:0] o_granted_addr;
    logic [15:0] o_granted_port;
    logic [3:0]  o_slot_index;
    logic [1:0]  o_status;

    // lock table copy kept by the testbench
    logic        lk_used   [NUM_SLOTS];
    logic [31:0] lk_key    [NUM_SLOTS];
    logic [47:0] lk_waiter [NUM_SLOTS][QUEUE_DEPTH];
    int          lk_head   [NUM_SLOTS];
    int          lk_count  [NUM_SLOTS];

    t_lock_result lock_result_q[$];
    t_lock_row    dir_rows [N_DIR];

    int errors;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_asks;
    int holds_done;
    int hold_left;
    int idle_cycles;

    resource_lock_fifo_manager_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_resource_key   (i_resource_key),
        .i_requester_addr (i_requester_addr),
        .i_requester_port (i_requester_port),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_grant          (o_grant),
        .o_granted_addr   (o_granted_addr),
        .o_granted_port   (o_granted_port),
        .o_slot_index     (o_slot_index),
        .o_status         (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_lock_result lock_table_step(input logic op, input logic [31:0] key,
                                                     input logic [31:0] addr,
                                                     input logic [15:0] port);
        t_lock_result r;
        int slot;
        int s;
        int pos;
        r = '0;
        r.status = ST_OK;
        slot = -1;
        for (s = 0; s < NUM_SLOTS; s++) begin
            if (slot < 0 && lk_used[s] && lk_key[s] == key) slot = s;
        end
        if (slot < 0) begin
            for (s = 0; s < NUM_SLOTS; s++) begin
                if (slot < 0 && !lk_used[s]) slot = s;
            end
            if (slot < 0) begin
                r.status = ST_TABLE_FULL;
                return r;
            end
            lk_used[slot]  = 1'b1;
            lk_key[slot]   = key;
            lk_head[slot]  = 0;
            lk_count[slot] = 0;
        end
        r.slot = 4'(slot);
        if (op == OP_ENTER) begin
            if (lk_count[slot] >= QUEUE_DEPTH) begin
                r.status = ST_QUEUE_FULL;
                return r;
            end
            pos = (lk_head[slot] + lk_count[slot]) % QUEUE_DEPTH;
            lk_waiter[slot][pos] = {addr, port};
            if (lk_count[slot] == 0) begin
                r.grant = 1'b1;
                r.addr  = addr;
                r.port  = port;
            end
            lk_count[slot] = lk_count[slot] + 1;
            return r;
        end
        if (lk_count[slot] == 0) begin
            r.status = ST_EMPTY_LEAVE;
            return r;
        end
        lk_head[slot]  = (lk_head[slot] + 1) % QUEUE_DEPTH;
        lk_count[slot] = lk_count[slot] - 1;
        // the next waiter in line takes over the lock
        if (lk_count[slot] != 0) begin
            r.grant = 1'b1;
            r.addr  = lk_waiter[slot][lk_head[slot]][47:16];
            r.port  = lk_waiter[slot][lk_head[slot]][15:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic offer_request(input logic op, input logic [31:0] key,
                                 input logic [31:0] addr, input logic [15:0] port,
                                 input bit typed, input t_lock_result want);
        t_lock_result model;
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_resource_key   <= key;
        i_requester_addr <= addr;
        i_requester_port <= port;
        do @(posedge i_clk); while (!o_in_ready);
        model = lock_table_step(op, key, addr, port);
        lock_result_q.push_back(typed ? want : model);
    endtask

    task automatic pace_sender();
        int gap;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        wait (lock_result_q.size() == 0);
        @(posedge i_clk);
    endtask

    // result side: checks each transaction, then picks ready for the next cycle
    always @(posedge i_clk) begin : result_check
        t_lock_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lock_result_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, slot %0d status %0d",
                                          o_slot_index, o_status));
            end else begin
                want = lock_result_q.pop_front();
                if (o_grant !== want.grant)
                    report_mismatch($sformatf("grant %b, want %b", o_grant, want.grant));
                if (o_granted_addr !== want.addr)
                    report_mismatch($sformatf("granted_addr %h, want %h",
                                              o_granted_addr, want.addr));
                if (o_granted_port !== want.port)
                    report_mismatch($sformatf("granted_port %h, want %h",
                                              o_granted_port, want.port));
                if (o_slot_index !== want.slot)
                    report_mismatch($sformatf("slot_index %0d, want %0d",
                                              o_slot_index, want.slot));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
            end
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_asks != holds_done) begin
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            holds_done  <= hold_asks;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        t_lock_row    row;
        t_lock_result want;
        int           hot_a;
        int           hot_b;
        int           slot;
        int           enter_pct;
        int           n;
        int           i;
        logic         op;
        logic [31:0]  key;

        errors       = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_asks    = 0;
        holds_done   = 0;
        hold_left    = 0;
        idle_cycles  = 0;
        for (n = 0; n < NUM_SLOTS; n++) begin
            lk_used[n]  = 1'b0;
            lk_key[n]   = '0;
            lk_head[n]  = 0;
            lk_count[n] = 0;
        end

        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_operation      <= OP_ENTER;
        i_resource_key   <= '0;
        i_requester_addr <= '0;
        i_requester_port <= '0;
        i_out_ready      <= 1'b0;

        //    op        key           addr          port     reps  kst   typ
        //    grant addr / port / slot / status
        dir_rows = '{
            '{OP_ENTER, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 5'd1,  1'b0, 1'b1,
              1'b1, 32'hFFFF_FFFF, 16'hFFFF, 4'd0, ST_OK},
            '{OP_ENTER, 32'h0000_0000, 32'h0000_0000, 16'h0000, 5'd1,  1'b0, 1'b1,
              1'b0, 32'h0, 16'h0, 4'd0, ST_OK},
            // pop of the first holder hands the lock to the all-zero requester
            '{OP_LEAVE, 32'h0000_0000, 32'h5A5A_5A5A, 16'h1234, 5'd1,  1'b0, 1'b1,
              1'b1, 32'h0, 16'h0, 4'd0, ST_OK},
            '{OP_LEAVE, 32'h0000_0000, 32'h0000_0000, 16'h0000, 5'd1,  1'b0, 1'b1,
              1'b0, 32'h0, 16'h0, 4'd0, ST_OK},
            '{OP_LEAVE, 32'h0000_0000, 32'h1111_1111, 16'h2222, 5'd1,  1'b0, 1'b1,
              1'b0, 32'h0, 16'h0, 4'd0, ST_EMPTY_LEAVE},
            // stray leave on an unknown key still claims a slot
            '{OP_LEAVE, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000, 5'd1,  1'b0, 1'b1,
              1'b0, 32'h0, 16'h0, 4'd1, ST_EMPTY_LEAVE},
            '{OP_ENTER, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 16'h5555, 5'd1,  1'b0, 1'b1,
              1'b1, 32'hAAAA_AAAA, 16'h5555, 4'd1, ST_OK},
            '{OP_LEAVE, 32'hFFFF_FFFF, 32'h5555_5555, 16'hAAAA, 5'd1,  1'b0, 1'b1,
              1'b0, 32'h0, 16'h0, 4'd1, ST_OK},
            '{OP_ENTER, 32'h1234_5678, 32'h0A00_0001, 16'h1000, 5'd16, 1'b0, 1'b0,
              1'b0, 32'h0, 16'h0, 4'd0, ST_OK},
            '{OP_ENTER, 32'h1234_5678, 32'h0B00_0000, 16'h2000, 5'd1,  1'b0, 1'b1,
              1'b0, 32'h0, 16'h0, 4'd2, ST_QUEUE_FULL},
            '{OP_LEAVE, 32'h1234_5678, 32'h0000_0000, 16'h0000, 5'd1,  1'b0, 1'b0,
              1'b0, 32'h0, 16'h0, 4'd0, ST_OK},
            // refill after the pop, so the ring pointer wraps
            '{OP_ENTER, 32'h1234_5678, 32'h0C00_0000, 16'h3000, 5'd1,  1'b0, 1'b0,
              1'b0, 32'h0, 16'h0, 4'd0, ST_OK},
            '{OP_ENTER, 32'hA5A5_0000, 32'h0D00_0000, 16'h4000, 5'd13, 1'b1, 1'b0,
              1'b0, 32'h0, 16'h0, 4'd0, ST_OK},
            '{OP_ENTER, 32'hDEAD_BEEF, 32'h0E00_0000, 16'h5000, 5'd1,  1'b0, 1'b1,
              1'b0, 32'h0, 16'h0, 4'd0, ST_TABLE_FULL},
            '{OP_LEAVE, 32'h0BAD_F00D, 32'h0F00_0000, 16'h6000, 5'd1,  1'b0, 1'b1,
              1'b0, 32'h0, 16'h0, 4'd0, ST_TABLE_FULL}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < N_DIR; n++) begin
            row  = dir_rows[n];
            want = '{row.w_grant, row.w_addr, row.w_port, row.w_slot, row.w_status};
            for (i = 0; i < int'(row.reps); i++)
                offer_request(row.op, row.key + (row.kstep ? 32'(i) : 32'd0),
                              row.addr + 32'(i), row.port, row.typed, want);
        end
        drain_results();

        // table is full from here on: known keys exercise the queues, fresh keys bounce
        hot_a = 0;
        hot_b = 1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                drain_results();
                case (n / PHASE_ITEMS)
                    0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                    1: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
                    2: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
                    default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
                endcase
            end
            if (n == 20 || n == 330) hold_asks <= hold_asks + 1;
            if (n % 50 == 0) begin
                hot_a = $urandom_range(0, NUM_SLOTS - 1);
                hot_b = $urandom_range(0, NUM_SLOTS - 1);
            end
            enter_pct = ((n / 40) % 2 == 0) ? 75 : 25;
            slot = ($urandom_range(0, 99) < 70) ? (($urandom_range(0, 1) != 0) ? hot_a : hot_b)
                                                : $urandom_range(0, NUM_SLOTS - 1);
            key = ($urandom_range(0, 99) < 6) ? $urandom : lk_key[slot];
            op  = ($urandom_range(0, 99) < enter_pct) ? OP_ENTER : OP_LEAVE;
            pace_sender();
            offer_request(op, key, $urandom, 16'($urandom), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        wait (lock_result_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
